>>> sv/gff_pkg.sv
package gff_pkg;

    localparam int COORD_BITS     = 3;
    localparam int OUT_LABEL_BITS = 8;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t                     func;
        logic [COORD_BITS-1:0]     first_index;
        logic [COORD_BITS-1:0]     second_index;
        logic [OUT_LABEL_BITS-1:0] label_value;
    } item_t;

    typedef struct packed
    {
        logic [COORD_BITS-1:0]     member_first;
        logic [COORD_BITS-1:0]     member_second;
        logic [OUT_LABEL_BITS-1:0] region_label;
        logic                      last_member;
    } result_t;

    // Grid position as held on the search stack
    typedef struct packed
    {
        logic [COORD_BITS-1:0] first;
        logic [COORD_BITS-1:0] second;
    } coord_t;

    typedef struct packed
    {
        logic rd;
        logic wr;
        logic wr_visited;
    } cell_cmd_t;

    typedef struct packed
    {
        logic clear;
        logic push;
        logic pop;
    } stack_cmd_t;

    typedef enum logic [1:0]
    {
        DIR_FIRST_INC  = 2'd0,
        DIR_FIRST_DEC  = 2'd1,
        DIR_SECOND_INC = 2'd2,
        DIR_SECOND_DEC = 2'd3
    } dir_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED_RD,
        ST_SEED_WR,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_RD,
        ST_NB_CHK,
        ST_EMIT
    } state_t;

endpackage

>>> sv/gff_ram.sv
module gff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/gff_cell_store.sv
module gff_cell_store
    import gff_pkg::*;
#(
    parameter int CELLS      = 64,
    parameter int LABEL_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_cmd_t                cmd,
    input  logic [$clog2(CELLS)-1:0] rd_addr,
    input  logic [$clog2(CELLS)-1:0] wr_addr,
    input  logic [LABEL_BITS-1:0]    wr_label,
    output logic [LABEL_BITS-1:0]    rd_label,
    output logic                     rd_visited
);

    logic [CELLS-1:0]    valid_reg;
    logic                rd_valid_reg;
    logic [LABEL_BITS:0] ram_rdata;

    // Entry layout: visited flag above the label
    gff_ram #(
        .WIDTH (LABEL_BITS + 1),
        .DEPTH (CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr),
        .wr_addr (wr_addr),
        .wr_data ({cmd.wr_visited, wr_label}),
        .rd_en   (cmd.rd),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // An entry never written since reset reads as label zero, not visited
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_label   = rd_valid_reg ? ram_rdata[LABEL_BITS-1:0] : '0;
    assign rd_visited = rd_valid_reg & ram_rdata[LABEL_BITS];

endmodule

>>> sv/gff_stack.sv
module gff_stack
    import gff_pkg::*;
#(
    parameter int CELLS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  stack_cmd_t                 cmd,
    input  coord_t                     push_data,
    output coord_t                     top_data,
    output logic [$clog2(CELLS+1)-1:0] depth
);

    localparam int AW = $clog2(CELLS);
    localparam int DW = $clog2(CELLS + 1);

    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [DW-1:0] depth_dec;

    assign depth_dec = depth_reg - DW'(1);

    always_comb
    begin
        depth_next = depth_reg;
        priority if (cmd.clear)
        begin
            depth_next = '0;
        end
        else if (cmd.push)
        begin
            depth_next = depth_reg + DW'(1);
        end
        else if (cmd.pop)
        begin
            depth_next = depth_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // Push writes at the current depth, pop reads the entry below it
    gff_ram #(
        .WIDTH ($bits(coord_t)),
        .DEPTH (CELLS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (depth_reg[AW-1:0]),
        .wr_data (push_data),
        .rd_en   (cmd.pop),
        .rd_addr (depth_dec[AW-1:0]),
        .rd_data (top_data)
    );

    assign depth = depth_reg;

endmodule

>>> sv/gff_seq.sv
module gff_seq
    import gff_pkg::*;
#(
    parameter int GRID_SIDE  = 8,
    parameter int LABEL_BITS = 8
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       item_valid,
    output logic                                       item_ready,
    input  item_t                                      item,
    output logic                                       result_valid,
    input  logic                                       result_ready,
    output result_t                                    result,
    output cell_cmd_t                                  cell_cmd,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]     cell_rd_addr,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]     cell_wr_addr,
    output logic [LABEL_BITS-1:0]                      cell_wr_label,
    input  logic [LABEL_BITS-1:0]                      cell_rd_label,
    input  logic                                       cell_rd_visited,
    output stack_cmd_t                                 stk_cmd,
    output coord_t                                     stk_push_data,
    input  coord_t                                     stk_top_data,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE+1)-1:0]   stk_depth
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);

    localparam logic [COORD_BITS:0]   SIDE     = (COORD_BITS + 1)'(GRID_SIDE);
    localparam logic [COORD_BITS-1:0] SIDE_MAX = COORD_BITS'(GRID_SIDE - 1);
    localparam logic [DW-1:0]         CELLS_D  = DW'(CELLS);

    function automatic logic [AW-1:0] cell_addr(input coord_t c);
        logic [6:0] lin;
        lin = 7'(c.first) * 7'(GRID_SIDE) + 7'(c.second);
        return lin[AW-1:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [DW-1:0]           sweep_reg, sweep_next;
    coord_t                  seed_reg, seed_next;
    logic [LABEL_BITS-1:0]   seed_label_reg, seed_label_next;
    coord_t                  cur_reg, cur_next;
    dir_t                    dir_reg, dir_next;
    result_t                 result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic          item_fire;
    logic          item_in_grid;
    coord_t        item_pos;
    coord_t        nb;
    logic          nb_ok;
    logic          nb_take;
    logic          dir_last;
    logic          result_load;
    logic [DW-1:0] sweep_dec;

    assign item_ready     = (state_reg == ST_IDLE);
    assign item_fire      = item_valid & item_ready;
    assign item_pos.first  = item.first_index;
    assign item_pos.second = item.second_index;
    assign item_in_grid   = ({1'b0, item.first_index} < SIDE)
                          && ({1'b0, item.second_index} < SIDE);
    assign dir_last       = (dir_reg == DIR_SECOND_DEC);
    assign nb_take        = !cell_rd_visited && (cell_rd_label == seed_label_reg);
    assign result_load    = (state_reg == ST_EMIT) && (!result_valid_reg || result_ready);
    assign sweep_dec      = sweep_reg - DW'(1);

    // Neighbour of the current cell in the current direction
    always_comb
    begin
        nb    = cur_reg;
        nb_ok = 1'b0;
        unique case (dir_reg)
            DIR_FIRST_INC:
            begin
                nb_ok    = (cur_reg.first != SIDE_MAX);
                nb.first = cur_reg.first + COORD_BITS'(1);
            end
            DIR_FIRST_DEC:
            begin
                nb_ok    = (cur_reg.first != '0);
                nb.first = cur_reg.first - COORD_BITS'(1);
            end
            DIR_SECOND_INC:
            begin
                nb_ok     = (cur_reg.second != SIDE_MAX);
                nb.second = cur_reg.second + COORD_BITS'(1);
            end
            DIR_SECOND_DEC:
            begin
                nb_ok     = (cur_reg.second != '0);
                nb.second = cur_reg.second - COORD_BITS'(1);
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && item_in_grid && (item.func == FUNC_QUERY))
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (sweep_reg == CELLS_D)
                begin
                    state_next = ST_SEED_RD;
                end
            end
            ST_SEED_RD:  state_next = ST_SEED_WR;
            ST_SEED_WR:  state_next = ST_POP;
            ST_POP:
            begin
                state_next = (stk_depth == '0) ? ST_IDLE : ST_POP_WAIT;
            end
            ST_POP_WAIT: state_next = ST_NB_RD;
            ST_NB_RD:
            begin
                if (nb_ok)
                begin
                    state_next = ST_NB_CHK;
                end
                else if (dir_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_NB_CHK:
            begin
                state_next = dir_last ? ST_EMIT : ST_NB_RD;
            end
            ST_EMIT:
            begin
                if (result_load)
                begin
                    state_next = ST_POP;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Memory controls
    always_comb
    begin
        cell_cmd      = '0;
        cell_rd_addr  = '0;
        cell_wr_addr  = '0;
        cell_wr_label = cell_rd_label;
        stk_cmd       = '0;
        stk_push_data = nb;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && item_in_grid)
                begin
                    if (item.func == FUNC_WRITE)
                    begin
                        cell_cmd.wr   = 1'b1;
                        cell_wr_addr  = cell_addr(item_pos);
                        cell_wr_label = LABEL_BITS'(item.label_value);
                    end
                    else
                    begin
                        stk_cmd.clear = 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                // Read one entry ahead, write back the previous with visited dropped
                cell_cmd.rd  = (sweep_reg != CELLS_D);
                cell_rd_addr = sweep_reg[AW-1:0];
                cell_cmd.wr  = (sweep_reg != '0);
                cell_wr_addr = sweep_dec[AW-1:0];
            end
            ST_SEED_RD:
            begin
                cell_cmd.rd  = 1'b1;
                cell_rd_addr = cell_addr(seed_reg);
            end
            ST_SEED_WR:
            begin
                cell_cmd.wr         = 1'b1;
                cell_cmd.wr_visited = 1'b1;
                cell_wr_addr        = cell_addr(seed_reg);
                stk_cmd.push        = 1'b1;
                stk_push_data       = seed_reg;
            end
            ST_POP:
            begin
                stk_cmd.pop = (stk_depth != '0);
            end
            ST_NB_RD:
            begin
                cell_cmd.rd  = nb_ok;
                cell_rd_addr = cell_addr(nb);
            end
            ST_NB_CHK:
            begin
                if (nb_take)
                begin
                    cell_cmd.wr         = 1'b1;
                    cell_cmd.wr_visited = 1'b1;
                    cell_wr_addr        = cell_addr(nb);
                    stk_cmd.push        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Datapath registers
    always_comb
    begin
        sweep_next        = sweep_reg;
        seed_next         = seed_reg;
        seed_label_next   = seed_label_reg;
        cur_next          = cur_reg;
        dir_next          = dir_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                sweep_next = '0;
                if (item_fire)
                begin
                    seed_next = item_pos;
                end
            end
            ST_CLEAR:    sweep_next      = sweep_reg + DW'(1);
            ST_SEED_WR:  seed_label_next = cell_rd_label;
            ST_POP_WAIT:
            begin
                cur_next = stk_top_data;
                dir_next = DIR_FIRST_INC;
            end
            ST_NB_RD:
            begin
                if (!nb_ok)
                begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end
            ST_NB_CHK:   dir_next = dir_t'(dir_reg + 2'd1);
            ST_EMIT:
            begin
                if (result_load)
                begin
                    result_next.member_first  = cur_reg.first;
                    result_next.member_second = cur_reg.second;
                    result_next.region_label  = OUT_LABEL_BITS'(seed_label_reg);
                    result_next.last_member   = (stk_depth == '0);
                    result_valid_next         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sweep_reg        <= '0;
            dir_reg          <= DIR_FIRST_INC;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            dir_reg          <= dir_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg       <= seed_next;
        seed_label_reg <= seed_label_next;
        cur_reg        <= cur_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> sv/grid_flood_fill_group.sv
// Flood-fill unit over a GRID_SIDE x GRID_SIDE grid of class labels.
// Input channel (item_valid/item_ready/item): a write transaction stores one
// cell label and completes in the cycle it is accepted, so writes can follow
// back to back; a query transaction searches the 4-connected region sharing
// the seed cell's label.
// Output channel (result_valid/result_ready/result): one transaction per
// region member in depth-first pop order, last_member set on the final one.
// A query with a position off the grid, and every write, gives no result.
// Course of a query: a visited-flag sweep over all GRID_SIDE*GRID_SIDE cells,
// a read and a marking write for the seed, then per member a pop, a stack
// read, a read and a check for each in-grid neighbour, a step for each
// direction off the grid and a load of the result, and at the end a pop
// that finds the stack empty.
// The single read port of the cell memory sets the per-neighbour cost.
// One item is in work at a time: item_ready is high only between queries.
// When the receiver stalls, the finished member waits in the output register
// and the search holds until it is taken.
// Reset clears the label grid to zero through per-cell valid flags, empties
// the stack and drops any pending result; no reset sweep is needed.
module grid_flood_fill_group
    import gff_pkg::*;
#(
    parameter int GRID_SIDE  = 8,
    parameter int LABEL_BITS = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);

    cell_cmd_t             cell_cmd;
    logic [AW-1:0]         cell_rd_addr;
    logic [AW-1:0]         cell_wr_addr;
    logic [LABEL_BITS-1:0] cell_wr_label;
    logic [LABEL_BITS-1:0] cell_rd_label;
    logic                  cell_rd_visited;
    stack_cmd_t            stk_cmd;
    coord_t                stk_push_data;
    coord_t                stk_top_data;
    logic [DW-1:0]         stk_depth;

    gff_seq #(
        .GRID_SIDE  (GRID_SIDE),
        .LABEL_BITS (LABEL_BITS)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (result),
        .cell_cmd        (cell_cmd),
        .cell_rd_addr    (cell_rd_addr),
        .cell_wr_addr    (cell_wr_addr),
        .cell_wr_label   (cell_wr_label),
        .cell_rd_label   (cell_rd_label),
        .cell_rd_visited (cell_rd_visited),
        .stk_cmd         (stk_cmd),
        .stk_push_data   (stk_push_data),
        .stk_top_data    (stk_top_data),
        .stk_depth       (stk_depth)
    );

    gff_cell_store #(
        .CELLS      (CELLS),
        .LABEL_BITS (LABEL_BITS)
    ) u_cells (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cell_cmd),
        .rd_addr    (cell_rd_addr),
        .wr_addr    (cell_wr_addr),
        .wr_label   (cell_wr_label),
        .rd_label   (cell_rd_label),
        .rd_visited (cell_rd_visited)
    );

    gff_stack #(
        .CELLS (CELLS)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (stk_cmd),
        .push_data (stk_push_data),
        .top_data  (stk_top_data),
        .depth     (stk_depth)
    );

endmodule

>>> sv/gff_checker.sv
module gff_checker
    import gff_pkg::*;
#(
    parameter int GRID_SIDE = 8
) (
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    localparam logic [COORD_BITS:0] SIDE = (COORD_BITS + 1)'(GRID_SIDE);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_member_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, result.member_first} < SIDE)
                      && ({1'b0, result.member_second} < SIDE))
        else $error("region member off the grid");

    // No new transaction while a region is still being delivered
    a_busy_mid_region: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last_member |=> !item_ready)
        else $error("input taken before region finished");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.func == FUNC_QUERY)
        && ({1'b0, item.first_index} < SIDE) && ({1'b0, item.second_index} < SIDE)
        |=> !item_ready)
        else $error("input ready straight after a query");

endmodule

bind grid_flood_fill_group gff_checker #(
    .GRID_SIDE (GRID_SIDE)
) u_gff_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

>>> bench/grid_flood_fill_group_tb.sv
`timescale 1ns / 100ps

module grid_flood_fill_group_tb;
    import gff_pkg::*;

    localparam int SIDE        = 8;
    localparam int CELLS       = SIDE * SIDE;
    localparam int STIM_ITEMS  = 380;
    localparam int CALM_TAIL   = 40;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 800;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    item_t      pending_items[$];
    result_t    expected_members[$];
    logic [7:0] label_store [CELLS] = '{default: 8'h00};
    logic [7:0] tone [4];
    int         send_gap;
    int         take_gap;
    int         quiet_cycles;
    int         error_count;
    logic       calm = 1'b0;

    grid_flood_fill_group #(
        .GRID_SIDE  (SIDE),
        .LABEL_BITS (8)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Apply one accepted transaction to the label store; for a query, walk the
    // region depth first and queue one expected member per pop.
    task automatic predict_region(input item_t it);
        logic [5:0]  seed_cell;
        logic [5:0]  cur;
        logic [7:0]  seed_label;
        logic [63:0] seen;
        logic [5:0]  lifo [CELLS];
        int          depth;
        int          nf;
        int          ns;
        int          k;
        int          nc;
        result_t     member;
        seed_cell = 6'(it.first_index * SIDE + it.second_index);
        if (it.func == FUNC_WRITE)
        begin
            label_store[seed_cell] = it.label_value;
            return;
        end
        seen            = '0;
        seed_label      = label_store[seed_cell];
        seen[seed_cell] = 1'b1;
        lifo[0]         = seed_cell;
        depth           = 1;
        while (depth > 0)
        begin
            depth--;
            cur = lifo[depth];
            for (k = 0; k < 4; k++)
            begin
                nf = cur / SIDE;
                ns = cur % SIDE;
                case (dir_t'(k))
                    DIR_FIRST_INC:  nf = nf + 1;
                    DIR_FIRST_DEC:  nf = nf - 1;
                    DIR_SECOND_INC: ns = ns + 1;
                    DIR_SECOND_DEC: ns = ns - 1;
                endcase
                if (nf < 0 || nf >= SIDE || ns < 0 || ns >= SIDE)
                    continue;
                nc = nf * SIDE + ns;
                if (!seen[nc] && label_store[nc] == seed_label)
                begin
                    seen[nc]    = 1'b1;
                    lifo[depth] = nc[5:0];
                    depth++;
                end
            end
            member.member_first  = COORD_BITS'(cur / SIDE);
            member.member_second = COORD_BITS'(cur % SIDE);
            member.region_label  = seed_label;
            member.last_member   = (depth == 0);
            expected_members.insert(expected_members.size(), member);
        end
    endtask

    task automatic check_member(input result_t got);
        result_t want;
        if (expected_members.size() == 0)
        begin
            report_error($sformatf("unexpected member (%0d,%0d) label %02h last %0b",
                got.member_first, got.member_second, got.region_label, got.last_member));
            return;
        end
        want = expected_members.pop_front();
        if (got.member_first !== want.member_first)
            report_error($sformatf("member_first %0d, want %0d",
                got.member_first, want.member_first));
        if (got.member_second !== want.member_second)
            report_error($sformatf("member_second %0d, want %0d",
                got.member_second, want.member_second));
        if (got.region_label !== want.region_label)
            report_error($sformatf("region_label %02h, want %02h",
                got.region_label, want.region_label));
        if (got.last_member !== want.last_member)
            report_error($sformatf("last_member %0b, want %0b",
                got.last_member, want.last_member));
    endtask

    function automatic void queue_item(input func_t f, input int fi, input int si,
                                       input int lbl);
        item_t it;
        it.func         = f;
        it.first_index  = fi[2:0];
        it.second_index = si[2:0];
        it.label_value  = lbl[7:0];
        pending_items.insert(pending_items.size(), it);
    endfunction

    // Driver: hold the transaction until taken, then load the next one or idle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            calm <= (pending_items.size() <= CALM_TAIL);
            if (item_valid && item_ready)
                predict_region(item);
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0 && !calm)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    send_gap = 0;
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 4);
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each member taken, then decide whether to stall.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_member(result);
            if (take_gap > 0 && !calm)
            begin
                take_gap--;
                result_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                take_gap = $urandom_range(0, 3);
                result_ready <= 1'b0;
            end
            else
            begin
                take_gap = 0;
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int shape;
        int n;
        int f0;
        int s0;
        int h;
        int w;
        int lbl;
        int a;
        int b;

        // Grid straight out of reset: one region of label zero covering everything
        queue_item(FUNC_QUERY, 0, 0, 0);
        queue_item(FUNC_QUERY, 7, 7, 8'hFF);
        // Corners at the label extremes
        queue_item(FUNC_WRITE, 0, 0, 8'hFF);
        queue_item(FUNC_WRITE, 7, 7, 8'hFF);
        queue_item(FUNC_WRITE, 0, 7, 8'h80);
        queue_item(FUNC_WRITE, 7, 0, 8'h01);
        queue_item(FUNC_QUERY, 0, 0, 0);
        queue_item(FUNC_QUERY, 3, 4, 0);
        queue_item(FUNC_QUERY, 7, 0, 8'h5A);
        // Split the grid with a wall along second index 3
        for (a = 0; a < SIDE; a++)
            queue_item(FUNC_WRITE, a, 3, 8'hAA);
        queue_item(FUNC_QUERY, 2, 1, 0);
        queue_item(FUNC_QUERY, 5, 6, 0);
        queue_item(FUNC_QUERY, 4, 3, 0);
        queue_item(FUNC_WRITE, 7, 7, 8'h55);
        queue_item(FUNC_QUERY, 7, 7, 0);

        tone[0] = 8'h00;
        for (a = 1; a < 4; a++)
            tone[a] = 8'($urandom_range(0, 255));

        while (pending_items.size() < STIM_ITEMS)
        begin
            shape = $urandom_range(0, 99);
            if (shape < 45)
            begin
                // scattered writes from a small set of labels, then query
                n = $urandom_range(1, 12);
                repeat (n)
                    queue_item(FUNC_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
                               tone[$urandom_range(0, 3)]);
                repeat ($urandom_range(1, 2))
                    queue_item(FUNC_QUERY, $urandom_range(0, 7), $urandom_range(0, 7),
                               $urandom_range(0, 255));
            end
            else if (shape < 80)
            begin
                // paint a block of one label and query from its corner
                f0  = $urandom_range(0, 7);
                s0  = $urandom_range(0, 7);
                h   = $urandom_range(1, 4);
                w   = $urandom_range(1, 4);
                lbl = tone[$urandom_range(0, 3)];
                for (a = 0; a < h; a++)
                    for (b = 0; b < w; b++)
                        if (f0 + a < SIDE && s0 + b < SIDE)
                            queue_item(FUNC_WRITE, f0 + a, s0 + b, lbl);
                queue_item(FUNC_QUERY, f0, s0, $urandom_range(0, 255));
            end
            else
            begin
                queue_item(func_t'($urandom_range(0, 1)), $urandom_range(0, 7),
                           $urandom_range(0, 7), $urandom_range(0, 255));
                tone[$urandom_range(1, 3)] = 8'($urandom_range(0, 255));
            end
        end

        wait (rst_n === 1'b1);
        while (pending_items.size() > 0 || item_valid || expected_members.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
